[rtl/core/buddy_page_allocator_defines.svh]
// assertion macros for the buddy page allocator checker
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, masked during reset
`define BPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator check failed");

// next-cycle implication, masked during reset
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");

// next-cycle implication that also holds through reset
`define BPA_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");

`endif

[rtl/core/bpa_pkg.sv]
// types, constants and codes shared by the buddy page allocator modules
`default_nettype none
package bpa_pkg;

    localparam int ADDR_W      = 39;
    localparam int PC_W        = 13;
    localparam int CNT_W       = 13;
    localparam int ORD_W       = 4;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 40;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_NUM_PAGES  = 4096;
    localparam int DEF_MAX_ORDER  = 11;
    localparam int DEF_PAGE_SHIFT = 12;

    localparam logic [ADDR_W-1:0] REGION_START_RST = 39'h00_8000_0000;
    localparam logic [ADDR_W-1:0] REGION_END_RST   = 39'h00_8100_0000;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_NOMEM = 2'd3
    } status_t;

    typedef enum logic {
        REG_REGION_START = 1'b0,
        REG_REGION_END   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        JOB_ALLOC  = 2'd0,
        JOB_FREE   = 2'd1,
        JOB_REPORT = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t kind;
        status_t   status;
    } job_ctl_t;

    typedef enum logic [3:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_FIND,
        BS_HEAD,
        BS_U0,
        BS_U1,
        BS_U2,
        BS_T0,
        BS_T1,
        BS_P0,
        BS_P1,
        BS_DONE
    } back_state_t;

endpackage
`default_nettype wire

[rtl/core/buddy_page_allocator.sv]
// top level of the buddy page allocator
`default_nettype none
// Buddy page allocator. Each request allocates or frees a block of 2^order pages
// and gets exactly one response: the granted byte address and a status. A
// classifier checks and rounds requests and hands jobs through a two-entry queue
// to a list engine that walks the free lists. After reset the engine clears
// the link and pair stores entry by entry, during which s_tready stays low;
// configuration writes are taken meanwhile. Each link store and the pair-bit
// store has a single read/write port, which every unlink, push and toggle
// steps through.
module buddy_page_allocator #(
    parameter int NUM_PAGES  = bpa_pkg::DEF_NUM_PAGES,
    parameter int MAX_ORDER  = bpa_pkg::DEF_MAX_ORDER,
    parameter int PAGE_SHIFT = bpa_pkg::DEF_PAGE_SHIFT
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // s_tdata: page_count [12:0], block_address [51:13], zero pad above
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [bpa_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: cmd
    input  wire                              s_tuser,
    // m_tdata: granted_address [38:0], zero pad above
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [bpa_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: status [1:0]
    output logic [1:0]                       m_tuser,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [bpa_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire  [bpa_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bpa_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int PW = $clog2(NUM_PAGES);
    localparam int OW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int XW = ((PW > MAX_ORDER) ? PW : MAX_ORDER) + 1;
    localparam int CTW = $bits(bpa_pkg::job_ctl_t);
    localparam int JW = CTW + OW + XW;

    logic                        clearing;
    logic [bpa_pkg::ADDR_W-1:0]  region_start;
    logic                        fj_valid, fj_ready, bj_valid, bj_ready;
    bpa_pkg::job_ctl_t           fj_ctl, bj_ctl;
    logic [OW-1:0]               fj_order, bj_order;
    logic [XW-1:0]               fj_page, bj_page;
    logic [JW-1:0]               q_wdata, q_rdata;
    logic [bpa_pkg::ADDR_W-1:0]  res_addr;
    bpa_pkg::status_t            res_status;

    bpa_front #(
        .NUM_PAGES  (NUM_PAGES),
        .MAX_ORDER  (MAX_ORDER),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .clearing     (clearing),
        .region_start (region_start),
        .job_valid    (fj_valid),
        .job_ready    (fj_ready),
        .job_ctl      (fj_ctl),
        .job_order    (fj_order),
        .job_page     (fj_page)
    );

    // job packing across the queue
    assign q_wdata = {fj_ctl, fj_order, fj_page};
    assign bj_ctl   = bpa_pkg::job_ctl_t'(q_rdata[JW-1 -: CTW]);
    assign bj_order = q_rdata[XW +: OW];
    assign bj_page  = q_rdata[XW-1:0];

    bpa_queue #(
        .DW    (JW),
        .DEPTH (bpa_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_data  (q_wdata),
        .rd_valid (bj_valid),
        .rd_ready (bj_ready),
        .rd_data  (q_rdata)
    );

    bpa_back #(
        .NUM_PAGES  (NUM_PAGES),
        .MAX_ORDER  (MAX_ORDER),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clearing     (clearing),
        .job_valid    (bj_valid),
        .job_ready    (bj_ready),
        .job_ctl      (bj_ctl),
        .job_order    (bj_order),
        .job_page     (bj_page),
        .region_start (region_start),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_addr     (res_addr),
        .res_status   (res_status)
    );

    assign m_tdata = bpa_pkg::M_TDATA_W'(res_addr);
    assign m_tuser = res_status;

endmodule
`default_nettype wire

[rtl/core/bpa_front.sv]
// request intake, configuration registers and classification of requests into jobs
`default_nettype none
module bpa_front #(
    parameter int NUM_PAGES  = bpa_pkg::DEF_NUM_PAGES,
    parameter int MAX_ORDER  = bpa_pkg::DEF_MAX_ORDER,
    parameter int PAGE_SHIFT = bpa_pkg::DEF_PAGE_SHIFT,
    localparam int PW = $clog2(NUM_PAGES),
    localparam int OW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
    localparam int XW = ((PW > MAX_ORDER) ? PW : MAX_ORDER) + 1
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // s_tdata: page_count [12:0], block_address [51:13]
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [bpa_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: cmd
    input  wire                               s_tuser,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [bpa_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire  [bpa_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bpa_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  wire                               clearing,
    output logic [bpa_pkg::ADDR_W-1:0]        region_start,
    output logic                              job_valid,
    input  wire                               job_ready,
    output bpa_pkg::job_ctl_t                 job_ctl,
    output logic [OW-1:0]                     job_order,
    output logic [XW-1:0]                     job_page
);

    logic                          hold_valid_reg, hold_valid_next;
    logic                          hold_cmd_reg;
    logic [bpa_pkg::PC_W-1:0]      hold_pc_reg;
    logic [bpa_pkg::ADDR_W-1:0]    hold_addr_reg;
    logic [bpa_pkg::ADDR_W-1:0]    region_start_reg, region_end_reg;

    logic                          take;
    logic                          cfg_wr;
    bpa_pkg::cfg_reg_t             cfg_idx;
    logic [bpa_pkg::PC_W-1:0]      pc_m1;
    logic [bpa_pkg::ORD_W-1:0]     ord;
    logic                          too_big;
    logic [bpa_pkg::ADDR_W-1:0]    diff;
    logic [bpa_pkg::ADDR_W-1:0]    pgd;
    logic [bpa_pkg::ADDR_W-1:0]    align_mask;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = bpa_pkg::cfg_reg_t'(paddr[3]);

    always_comb begin
        unique case (cfg_idx)
            bpa_pkg::REG_REGION_START: prdata = bpa_pkg::CFG_DATA_W'(region_start_reg);
            bpa_pkg::REG_REGION_END:   prdata = bpa_pkg::CFG_DATA_W'(region_end_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_start_reg <= bpa_pkg::REGION_START_RST;
            region_end_reg   <= bpa_pkg::REGION_END_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                bpa_pkg::REG_REGION_START: region_start_reg <= pwdata[bpa_pkg::ADDR_W-1:0];
                bpa_pkg::REG_REGION_END:   region_end_reg   <= pwdata[bpa_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign region_start = region_start_reg;

    // one-entry holding stage in front of the classifier
    assign s_tready = !clearing && (!hold_valid_reg || job_ready);
    assign take     = s_tvalid && s_tready;
    assign job_valid = hold_valid_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (hold_valid_reg && job_ready) begin
            hold_valid_next = 1'b0;
        end
        if (take) begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            hold_cmd_reg  <= s_tuser;
            hold_pc_reg   <= s_tdata[bpa_pkg::PC_W-1:0];
            hold_addr_reg <= s_tdata[bpa_pkg::PC_W +: bpa_pkg::ADDR_W];
        end
    end

    // round page count up to a power-of-two order
    assign pc_m1 = hold_pc_reg - bpa_pkg::PC_W'(1);

    always_comb begin
        ord = '0;
        if (hold_pc_reg > bpa_pkg::PC_W'(1)) begin
            for (int i = 0; i < bpa_pkg::PC_W; i++) begin
                if (pc_m1[i]) begin
                    ord = bpa_pkg::ORD_W'(i + 1);
                end
            end
        end
    end

    assign too_big    = int'(ord) >= MAX_ORDER;
    assign diff       = hold_addr_reg - region_start_reg;
    assign pgd        = diff >> PAGE_SHIFT;
    assign align_mask = ~((bpa_pkg::ADDR_W'(1) << ord) - bpa_pkg::ADDR_W'(1));

    // classify into a job for the back end
    always_comb begin
        job_ctl.kind   = bpa_pkg::JOB_REPORT;
        job_ctl.status = bpa_pkg::STAT_OK;
        job_order      = OW'(ord);
        job_page       = XW'(pgd & align_mask);
        if (hold_cmd_reg == bpa_pkg::CMD_ALLOC) begin
            if (too_big) begin
                job_ctl.status = bpa_pkg::STAT_NOMEM;
            end else begin
                job_ctl.kind = bpa_pkg::JOB_ALLOC;
            end
        end else if (hold_addr_reg == '0) begin
            job_ctl.status = bpa_pkg::STAT_NULL;
        end else if (hold_addr_reg < region_start_reg || hold_addr_reg > region_end_reg) begin
            job_ctl.status = bpa_pkg::STAT_RANGE;
        end else if (pgd >= bpa_pkg::ADDR_W'(NUM_PAGES)) begin
            job_ctl.status = bpa_pkg::STAT_RANGE;
        end else if (too_big) begin
            job_ctl.status = bpa_pkg::STAT_NOMEM;
        end else begin
            job_ctl.kind = bpa_pkg::JOB_FREE;
        end
    end

endmodule
`default_nettype wire

[rtl/core/bpa_queue.sv]
// small register queue that decouples the classifier from the list engine
`default_nettype none
module bpa_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = bpa_pkg::QUEUE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           wr_valid,
    output logic          wr_ready,
    input  wire  [DW-1:0] wr_data,
    output logic          rd_valid,
    input  wire           rd_ready,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] slot_reg [DEPTH];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push, pop;

    assign wr_ready = cnt_reg != CW'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rp_reg];

    // pointer and fill updates
    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        end
        if (pop) begin
            rp_next = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

[rtl/core/bpa_back.sv]
// list engine: free lists, links, pair bits, split and merge sequencing, result register
`default_nettype none
module bpa_back #(
    parameter int NUM_PAGES  = bpa_pkg::DEF_NUM_PAGES,
    parameter int MAX_ORDER  = bpa_pkg::DEF_MAX_ORDER,
    parameter int PAGE_SHIFT = bpa_pkg::DEF_PAGE_SHIFT,
    localparam int PW = $clog2(NUM_PAGES),
    localparam int OW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
    localparam int XW = ((PW > MAX_ORDER) ? PW : MAX_ORDER) + 1
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    output logic                         clearing,
    input  wire                          job_valid,
    output logic                         job_ready,
    input  wire  bpa_pkg::job_ctl_t      job_ctl,
    input  wire  [OW-1:0]                job_order,
    input  wire  [XW-1:0]                job_page,
    input  wire  [bpa_pkg::ADDR_W-1:0]   region_start,
    output logic                         res_valid,
    input  wire                          res_ready,
    output logic [bpa_pkg::ADDR_W-1:0]   res_addr,
    output bpa_pkg::status_t             res_status
);

    bpa_pkg::back_state_t state_reg, state_next;

    // job context
    logic                   is_free_reg;
    logic                   grant_reg;
    bpa_pkg::status_t       stat_reg;
    logic [OW-1:0]          ord_reg;
    logic [OW-1:0]          o_reg;
    logic [XW-1:0]          pg_reg;
    logic [XW-1:0]          op_reg;
    logic [PW-1:0]          clr_reg;

    // per-order list heads and counts
    logic [PW-1:0]          head_reg [MAX_ORDER];
    logic                   hok_reg  [MAX_ORDER];
    logic [bpa_pkg::CNT_W-1:0] cnt_reg [MAX_ORDER];

    // link and pair stores, entry = {valid flag, link}
    logic [PW:0]            next_mem [NUM_PAGES];
    logic [PW:0]            prev_mem [NUM_PAGES];
    logic                   pair_mem [NUM_PAGES];
    logic [PW:0]            nrd_reg, prd_reg;
    logic                   brd_reg;

    // result register
    logic                      out_valid_reg;
    logic [bpa_pkg::ADDR_W-1:0] out_addr_reg;
    bpa_pkg::status_t          out_stat_reg;

    // memory controls
    logic          next_we, prev_we, pair_we, link_re, pair_re;
    logic [PW-1:0] next_wa, prev_wa, pair_wa;
    logic [PW:0]   next_wd, prev_wd;
    logic          pair_wd;

    logic          op_in, pg_in, pos_in;
    logic [XW:0]   pos;
    logic [PW-1:0] hd;
    logic          hok;
    logic [XW-1:0] stride;
    logic          found;
    logic [OW-1:0] k;
    logic          tog_bit, merge_go, at_head;
    logic          nok, pok;
    logic [PW-1:0] n, q;
    logic          out_load;

    assign op_in  = op_reg < XW'(NUM_PAGES);
    assign pg_in  = pg_reg < XW'(NUM_PAGES);
    assign pos    = (XW+1)'(NUM_PAGES - (NUM_PAGES >> o_reg))
                  + (XW+1)'(pg_reg >> (o_reg + OW'(1)));
    assign pos_in = pos < (XW+1)'(NUM_PAGES);
    assign hd     = head_reg[o_reg];
    assign hok    = hok_reg[o_reg];
    assign stride = XW'(1) << o_reg;
    assign nok    = nrd_reg[PW];
    assign n      = nrd_reg[PW-1:0];
    assign pok    = prd_reg[PW];
    assign q      = prd_reg[PW-1:0];
    assign tog_bit  = pos_in && !brd_reg;
    assign merge_go = !tog_bit && (int'(o_reg) + 1 < MAX_ORDER);
    assign at_head  = !pok && hok && (XW'(hd) == op_reg);
    assign clearing  = state_reg == bpa_pkg::BS_CLEAR;
    assign job_ready = state_reg == bpa_pkg::BS_IDLE;
    assign out_load  = (state_reg == bpa_pkg::BS_DONE) && (!out_valid_reg || res_ready);

    // lowest nonempty order at or above the request
    always_comb begin
        found = 1'b0;
        k     = '0;
        for (int i = MAX_ORDER - 1; i >= 0; i--) begin
            if (i >= int'(ord_reg) && cnt_reg[i] != '0) begin
                found = 1'b1;
                k     = OW'(i);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::BS_CLEAR: begin
                if (clr_reg == PW'(NUM_PAGES - 1)) begin
                    state_next = bpa_pkg::BS_IDLE;
                end
            end
            bpa_pkg::BS_IDLE: begin
                if (job_valid) begin
                    unique case (job_ctl.kind)
                        bpa_pkg::JOB_ALLOC: state_next = bpa_pkg::BS_FIND;
                        bpa_pkg::JOB_FREE:  state_next = bpa_pkg::BS_T0;
                        default:            state_next = bpa_pkg::BS_DONE;
                    endcase
                end
            end
            bpa_pkg::BS_FIND: state_next = found ? bpa_pkg::BS_HEAD : bpa_pkg::BS_DONE;
            bpa_pkg::BS_HEAD: state_next = bpa_pkg::BS_U0;
            bpa_pkg::BS_U0:   state_next = op_in ? bpa_pkg::BS_U1 : bpa_pkg::BS_U2;
            bpa_pkg::BS_U1:   state_next = bpa_pkg::BS_U2;
            bpa_pkg::BS_U2:   state_next = bpa_pkg::BS_T0;
            bpa_pkg::BS_T0:   state_next = bpa_pkg::BS_T1;
            bpa_pkg::BS_T1: begin
                if (is_free_reg) begin
                    state_next = merge_go ? bpa_pkg::BS_U0 : bpa_pkg::BS_P0;
                end else begin
                    state_next = (o_reg > ord_reg) ? bpa_pkg::BS_P0 : bpa_pkg::BS_DONE;
                end
            end
            bpa_pkg::BS_P0:   state_next = bpa_pkg::BS_P1;
            bpa_pkg::BS_P1:   state_next = is_free_reg ? bpa_pkg::BS_DONE : bpa_pkg::BS_T0;
            bpa_pkg::BS_DONE: begin
                if (out_load) begin
                    state_next = bpa_pkg::BS_IDLE;
                end
            end
            default: state_next = bpa_pkg::BS_IDLE;
        endcase
    end

    // memory port controls per state
    always_comb begin
        next_we = 1'b0;
        prev_we = 1'b0;
        pair_we = 1'b0;
        link_re = 1'b0;
        pair_re = 1'b0;
        next_wa = op_reg[PW-1:0];
        prev_wa = op_reg[PW-1:0];
        pair_wa = pos[PW-1:0];
        next_wd = '0;
        prev_wd = '0;
        pair_wd = !brd_reg;
        unique case (state_reg)
            bpa_pkg::BS_CLEAR: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                pair_we = 1'b1;
                next_wa = clr_reg;
                prev_wa = clr_reg;
                pair_wa = clr_reg;
                pair_wd = 1'b0;
            end
            bpa_pkg::BS_U0: begin
                link_re = op_in;
            end
            bpa_pkg::BS_U1: begin
                // splice neighbors around the unlinked block
                if (pok) begin
                    next_we = 1'b1;
                    next_wa = q;
                    next_wd = {nok, n};
                    if (nok) begin
                        prev_we = 1'b1;
                        prev_wa = n;
                        prev_wd = {1'b1, q};
                    end
                end else if (at_head && nok) begin
                    prev_we = 1'b1;
                    prev_wa = n;
                    prev_wd = '0;
                end
            end
            bpa_pkg::BS_U2: begin
                // drop own flags, keep link values
                next_we = op_in;
                prev_we = op_in;
                next_wd = {1'b0, n};
                prev_wd = {1'b0, q};
            end
            bpa_pkg::BS_T0: begin
                pair_re = pos_in;
            end
            bpa_pkg::BS_T1: begin
                pair_we = pos_in;
            end
            bpa_pkg::BS_P0: begin
                next_we = pg_in;
                next_wa = pg_reg[PW-1:0];
                next_wd = {hok, hd};
                if (hok) begin
                    prev_we = pg_in;
                    prev_wa = hd;
                    prev_wd = {1'b1, pg_reg[PW-1:0]};
                end
            end
            bpa_pkg::BS_P1: begin
                prev_we = pg_in;
                prev_wa = pg_reg[PW-1:0];
                prev_wd = '0;
            end
            default: ;
        endcase
    end

    // link and pair stores
    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (link_re) begin
            nrd_reg <= next_mem[op_reg[PW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (link_re) begin
            prd_reg <= prev_mem[op_reg[PW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pair_we) begin
            pair_mem[pair_wa] <= pair_wd;
        end
        if (pair_re) begin
            brd_reg <= pair_mem[pos[PW-1:0]];
        end
    end

    // sequencer state and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpa_pkg::BS_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == bpa_pkg::BS_CLEAR) begin
                clr_reg <= clr_reg + PW'(1);
            end
        end
    end

    // heads, flags and counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                head_reg[i] <= '0;
                hok_reg[i]  <= 1'b0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            case (state_reg)
                bpa_pkg::BS_U1: begin
                    if (at_head) begin
                        head_reg[o_reg] <= n;
                        hok_reg[o_reg]  <= nok;
                    end
                end
                bpa_pkg::BS_U2: begin
                    cnt_reg[o_reg] <= cnt_reg[o_reg] - bpa_pkg::CNT_W'(1);
                end
                bpa_pkg::BS_P1: begin
                    cnt_reg[o_reg] <= cnt_reg[o_reg] + bpa_pkg::CNT_W'(1);
                    if (pg_in) begin
                        head_reg[o_reg] <= pg_reg[PW-1:0];
                        hok_reg[o_reg]  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // job context updates
    always_ff @(posedge aclk) begin
        case (state_reg)
            bpa_pkg::BS_IDLE: begin
                if (job_valid) begin
                    is_free_reg <= job_ctl.kind == bpa_pkg::JOB_FREE;
                    grant_reg   <= job_ctl.kind == bpa_pkg::JOB_ALLOC;
                    stat_reg    <= job_ctl.status;
                    ord_reg     <= job_order;
                    o_reg       <= job_order;
                    pg_reg      <= job_page;
                end
            end
            bpa_pkg::BS_FIND: begin
                if (found) begin
                    o_reg <= k;
                end else begin
                    stat_reg  <= bpa_pkg::STAT_NOMEM;
                    grant_reg <= 1'b0;
                end
            end
            bpa_pkg::BS_HEAD: begin
                pg_reg <= XW'(hd);
                op_reg <= XW'(hd);
            end
            bpa_pkg::BS_U2: begin
                if (is_free_reg) begin
                    if (op_reg < pg_reg) begin
                        pg_reg <= op_reg;
                    end
                    o_reg <= o_reg + OW'(1);
                end
            end
            bpa_pkg::BS_T1: begin
                if (is_free_reg) begin
                    op_reg <= pg_reg ^ stride;
                end else if (o_reg > ord_reg) begin
                    o_reg <= o_reg - OW'(1);
                end
            end
            bpa_pkg::BS_P1: begin
                if (!is_free_reg) begin
                    pg_reg <= pg_reg + stride;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (res_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_stat_reg <= stat_reg;
            out_addr_reg <= grant_reg
                ? region_start + (bpa_pkg::ADDR_W'(pg_reg) << PAGE_SHIFT) : '0;
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_addr   = out_addr_reg;
    assign res_status = out_stat_reg;

endmodule
`default_nettype wire

[rtl/core/bpa_checker.sv]
// port-level checks on the buddy page allocator, bound to the top level
`default_nettype none
`include "buddy_page_allocator_defines.svh"
module bpa_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [bpa_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire [1:0]                      m_tuser
);

    // a stalled response holds
    `BPA_ASSERT_NEXT(a_resp_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // every failed transaction reports address zero
    `BPA_ASSERT_SAME(a_fail_zero, aclk, aresetn, m_tvalid && (m_tuser != bpa_pkg::STAT_OK), m_tdata == '0)

    // the store sweep after reset blocks intake and no response is pending
    `BPA_ASSERT_ALWAYS_NEXT(a_reset_quiet, aclk, !aresetn, !s_tready && !m_tvalid)

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the buddy page allocator
`default_nettype none

// one expected response transaction
typedef struct {
    logic [38:0]       granted;
    bpa_pkg::status_t  status;
} resp_t;

// free-list predictor and queue of expected responses
class bpa_scoreboard;
    localparam int PAGES = bpa_pkg::DEF_NUM_PAGES;
    localparam int ORDERS = bpa_pkg::DEF_MAX_ORDER;
    localparam int PSHIFT = bpa_pkg::DEF_PAGE_SHIFT;

    logic [38:0]  region_start;
    logic [38:0]  region_end;
    int unsigned  head_pg[ORDERS];
    bit           head_ok[ORDERS];
    logic [12:0]  free_cnt[ORDERS];
    int unsigned  nxt[PAGES];
    int unsigned  prv[PAGES];
    bit           nxt_ok[PAGES];
    bit           prv_ok[PAGES];
    bit           pair[PAGES];
    resp_t        pending[$];
    int           errors;
    int           checked;

    function new();
        region_start = bpa_pkg::REGION_START_RST;
        region_end   = bpa_pkg::REGION_END_RST;
        foreach (head_pg[i]) begin
            head_pg[i] = 0;
            head_ok[i] = 0;
            free_cnt[i] = '0;
        end
        foreach (nxt[i]) begin
            nxt[i] = 0;
            prv[i] = 0;
            nxt_ok[i] = 0;
            prv_ok[i] = 0;
            pair[i] = 0;
        end
        errors = 0;
        checked = 0;
    endfunction

    // flip the pair bit of a block, returns the new value
    function bit flip_pair(int unsigned pg, int unsigned o);
        int unsigned pos;
        pos = PAGES - (PAGES >> o) + (pg >> (o + 1));
        if (pos >= PAGES) return 0;
        pair[pos] ^= 1'b1;
        return pair[pos];
    endfunction

    function void push_free(int unsigned pg, int unsigned o);
        if (pg >= PAGES) return;
        nxt_ok[pg] = head_ok[o];
        nxt[pg] = head_pg[o];
        if (head_ok[o]) begin
            prv[head_pg[o]] = pg;
            prv_ok[head_pg[o]] = 1;
        end
        prv_ok[pg] = 0;
        head_pg[o] = pg;
        head_ok[o] = 1;
    endfunction

    function void unlink_free(int unsigned pg, int unsigned o);
        int unsigned q;
        if (pg >= PAGES) return;
        if (prv_ok[pg]) begin
            q = prv[pg];
            nxt[q] = nxt[pg];
            nxt_ok[q] = nxt_ok[pg];
            if (nxt_ok[pg]) begin
                prv[nxt[pg]] = q;
                prv_ok[nxt[pg]] = 1;
            end
        end else if (head_ok[o] && head_pg[o] == pg) begin
            head_pg[o] = nxt[pg];
            head_ok[o] = nxt_ok[pg];
            if (nxt_ok[pg]) prv_ok[nxt[pg]] = 0;
        end
        nxt_ok[pg] = 0;
        prv_ok[pg] = 0;
    endfunction

    // note an accepted request and queue its response
    function resp_t note_request(bpa_pkg::cmd_t cmd, logic [12:0] pc, logic [38:0] addr);
        resp_t r;
        int unsigned ord, k, blk, pg, o, buddy;
        logic [38:0] offs;
        ord = 0;
        while (ord < 13 && (1 << ord) < pc) ord++;
        r.granted = '0;
        r.status = bpa_pkg::STAT_OK;
        if (cmd == bpa_pkg::CMD_ALLOC) begin
            k = ord;
            while (k < ORDERS && free_cnt[k] == 0) k++;
            if (ord >= ORDERS || k >= ORDERS) begin
                r.status = bpa_pkg::STAT_NOMEM;
            end else begin
                blk = head_pg[k];
                unlink_free(blk, k);
                free_cnt[k] = free_cnt[k] - 1;
                void'(flip_pair(blk, k));
                for (int j = int'(k) - 1; j >= int'(ord); j--) begin
                    push_free(blk, j);
                    free_cnt[j] = free_cnt[j] + 1;
                    blk += 1 << j;
                    void'(flip_pair(blk, j));
                end
                r.granted = region_start + (39'(blk) << PSHIFT);
            end
        end else if (addr == '0) begin
            r.status = bpa_pkg::STAT_NULL;
        end else if (addr < region_start || addr > region_end) begin
            r.status = bpa_pkg::STAT_RANGE;
        end else begin
            offs = (addr - region_start) >> PSHIFT;
            if (offs >= PAGES) begin
                r.status = bpa_pkg::STAT_RANGE;
            end else if (ord >= ORDERS) begin
                r.status = bpa_pkg::STAT_NOMEM;
            end else begin
                o = ord;
                pg = int'(offs) & ~((1 << o) - 1);
                // merge upward while the buddy is free too
                forever begin
                    if (flip_pair(pg, o) == 0 && o + 1 < ORDERS) begin
                        buddy = pg ^ (1 << o);
                        unlink_free(buddy, o);
                        free_cnt[o] = free_cnt[o] - 1;
                        if (buddy < pg) pg = buddy;
                        o++;
                    end else begin
                        push_free(pg, o);
                        free_cnt[o] = free_cnt[o] + 1;
                        break;
                    end
                end
            end
        end
        pending.push_back(r);
        return r;
    endfunction

    // compare a response transaction with the oldest expectation
    function void check_response(logic [38:0] granted, logic [1:0] status);
        resp_t r;
        checked++;
        if (pending.size() == 0) begin
            $error("unexpected response: granted_address %h status %0d", granted, status);
            errors++;
            return;
        end
        r = pending.pop_front();
        if (granted !== r.granted) begin
            $error("granted_address: expected %h actual %h", r.granted, granted);
            errors++;
        end
        if (status !== r.status) begin
            $error("status: expected %0d actual %0d", r.status, status);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    typedef struct {
        int unsigned pg;
        int unsigned ord;
    } held_blk_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [bpa_pkg::S_TDATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [bpa_pkg::M_TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic psel;
    logic penable;
    logic pwrite;
    logic [bpa_pkg::CFG_ADDR_W-1:0] paddr;
    logic [bpa_pkg::CFG_DATA_W-1:0] pwdata;
    logic [bpa_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    bpa_scoreboard alloc_sb;
    held_blk_t held[$];
    bit steady;
    bit hold_off;
    int sent;
    int noise_sent;

    buddy_page_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // send one request and wait until it is accepted
    task automatic send_req(bpa_pkg::cmd_t cmd, logic [12:0] pc, logic [38:0] addr);
        resp_t r;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'b0, addr, pc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = alloc_sb.note_request(cmd, pc, addr);
        sent++;
        if (cmd == bpa_pkg::CMD_ALLOC && r.status == bpa_pkg::STAT_OK) begin
            int unsigned o;
            o = 0;
            while ((1 << o) < pc) o++;
            held.push_back('{int'((r.granted - alloc_sb.region_start) >> 12), o});
        end
        // random gap between requests
        if (!steady && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // configuration write, only with the request side idle
    task automatic write_reg(bpa_pkg::cfg_reg_t idx, logic [38:0] value);
        s_tvalid <= 1'b0;
        while (alloc_sb.pending.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= bpa_pkg::CFG_ADDR_W'(idx) << 3;
        pwdata <= 64'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == bpa_pkg::REG_REGION_START) alloc_sb.region_start = value;
        else alloc_sb.region_end = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [12:0] count_for(int unsigned o);
        if (o == 0) return 13'($urandom_range(0, 1));
        return 13'($urandom_range((1 << (o - 1)) + 1, 1 << o));
    endfunction

    function automatic logic [38:0] page_addr(int unsigned pg);
        return alloc_sb.region_start + (39'(pg) << 12);
    endfunction

    // one phase of mostly well-formed alloc and free traffic
    task automatic run_phase(int n);
        int sel, idx;
        int unsigned o;
        held_blk_t b;
        for (int i = 0; i < n; i++) begin
            steady = (sent >= 300 && sent < 550);
            hold_off = (sent >= 800 && sent < 806) ? 1'b1 : hold_off;
            sel = $urandom_range(99);
            if (sel < 72) begin
                if (held.size() > 0 && ($urandom_range(1) == 1 || held.size() > 60)) begin
                    idx = $urandom_range(held.size() - 1);
                    b = held[idx];
                    held.delete(idx);
                    // low address bits inside the block are dropped
                    send_req(bpa_pkg::CMD_FREE, count_for(b.ord),
                             page_addr(b.pg) + 39'($urandom_range(0, 1)
                                                   * $urandom_range(0, 4095)));
                end else begin
                    o = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
                    send_req(bpa_pkg::CMD_ALLOC, count_for(o), '0);
                end
            end else if (sel < 84) begin
                // stray free of a block that may not be held
                o = $urandom_range(0, 6);
                send_req(bpa_pkg::CMD_FREE, count_for(o),
                         page_addr($urandom_range(0, 4095) & ~((1 << o) - 1)));
            end else begin
                noise_sent++;
                send_req(bpa_pkg::cmd_t'($urandom_range(1)), 13'($urandom_range(0, 8191)),
                         {7'($urandom), $urandom});
            end
        end
    endtask

    // result side with random backpressure and one long hold-off
    initial begin
        int hold_cnt;
        m_tready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) alloc_sb.check_response(m_tdata[38:0], m_tuser);
            if (hold_off && hold_cnt < 400) begin
                hold_cnt++;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 29);
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        int idle_cnt;
        idle_cnt = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int waited;
        alloc_sb = new();
        steady = 1'b0;
        hold_off = 1'b0;
        sent = 0;
        noise_sent = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: error paths on an empty store
        send_req(bpa_pkg::CMD_ALLOC, 13'd1, '0);
        send_req(bpa_pkg::CMD_ALLOC, 13'd0, '0);
        send_req(bpa_pkg::CMD_FREE, 13'd1, '0);
        send_req(bpa_pkg::CMD_FREE, 13'd1, 39'h00_7FFF_FFFF);
        send_req(bpa_pkg::CMD_FREE, 13'd1, 39'h00_8100_0001);
        send_req(bpa_pkg::CMD_FREE, 13'd1, 39'h00_8100_0000);
        send_req(bpa_pkg::CMD_FREE, 13'd1, '1);
        send_req(bpa_pkg::CMD_FREE, 13'd4096, 39'h00_8000_0000);
        send_req(bpa_pkg::CMD_FREE, 13'd1025, 39'h00_8000_0000);
        send_req(bpa_pkg::CMD_FREE, 13'h1FFF, 39'h00_8000_0000);
        send_req(bpa_pkg::CMD_ALLOC, 13'd4096, '1);
        send_req(bpa_pkg::CMD_ALLOC, 13'd1025, '0);
        // fill the store with the four largest blocks
        for (int q = 0; q < 4; q++) send_req(bpa_pkg::CMD_FREE, 13'd1024, page_addr(q * 1024));
        // deep split, then unaligned free that merges all the way back
        send_req(bpa_pkg::CMD_ALLOC, 13'd1, '0);
        send_req(bpa_pkg::CMD_FREE, 13'd1, page_addr(held[$].pg) + 39'h0ABC);
        void'(held.pop_back());
        send_req(bpa_pkg::CMD_ALLOC, 13'd1024, '0);
        send_req(bpa_pkg::CMD_ALLOC, 13'd3, '0);
        send_req(bpa_pkg::CMD_ALLOC, 13'd2, '0);

        run_phase(420);
        write_reg(bpa_pkg::REG_REGION_START, '0);
        write_reg(bpa_pkg::REG_REGION_END, '1);
        run_phase(380);
        write_reg(bpa_pkg::REG_REGION_START, 39'h7F_FFFF_F000);
        run_phase(350);
        write_reg(bpa_pkg::REG_REGION_START, bpa_pkg::REGION_START_RST);
        write_reg(bpa_pkg::REG_REGION_END, bpa_pkg::REGION_START_RST);
        run_phase(150);
        write_reg(bpa_pkg::REG_REGION_END, bpa_pkg::REGION_END_RST);
        run_phase(230);

        // drain
        s_tvalid <= 1'b0;
        waited = 0;
        while (alloc_sb.pending.size() != 0 && waited < STALL_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (100) @(posedge aclk);
        $display("covered %0d requests (%0d random noise) and %0d responses",
                 sent, noise_sent, alloc_sb.checked);
        $display("over five region settings, with a long result-side hold-off");
        if (alloc_sb.errors == 0 && alloc_sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/bpa_front.sv
rtl/core/bpa_queue.sv
rtl/core/bpa_back.sv
rtl/core/buddy_page_allocator.sv
rtl/core/bpa_checker.sv
tb/sv/tb_top.sv
